FILE: rtl/box_filter_downscaler_defines.svh
// Assertion macros for the checker file bfd_checker.sv.
`ifndef BOX_FILTER_DOWNSCALER_DEFINES_SVH
`define BOX_FILTER_DOWNSCALER_DEFINES_SVH

// A condition that holds at every clock edge, reset included.
`define BFD_ASSERT_ALWAYS(label, clk, cond, msg) \
	label: assert property (@(posedge clk) cond) else $error(msg);

// A condition that holds in the same cycle as its trigger, outside reset.
`define BFD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) ante |-> cons) \
		else $error(msg);

// A condition that holds in the cycle after its trigger, outside reset.
`define BFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
		else $error(msg);

`endif

FILE: rtl/bfd_pkg.sv
`default_nettype none

package bfd_pkg;

	localparam int PIX_W = 24;
	localparam int CH_W = 8;
	localparam int NUM_CH = 3;
	localparam int LANE_W = 14;
	localparam int SUM_W = NUM_CH * LANE_W;
	localparam int POS_W = 10;
	localparam int SUB_W = 3;
	localparam int SHIFT_W = 2;
	localparam int DWIDTH_W = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 11;
	localparam int QUEUE_DEPTH = 4;
	localparam logic [DWIDTH_W-1:0] DWIDTH_RESET = 11'd640;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_SHIFT   = 1'b0,
		REG_DISPLAY_WIDTH = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [SUM_W-1:0]   seg;
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
		logic               first_row;
		logic               emit;
		logic [SHIFT_W-1:0] shift;
	} bfd_cmd_t;

	function automatic logic [SUM_W-1:0] lane_add(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W-1:0] r;
		for (int i = 0; i < NUM_CH; i++) begin
			r[i*LANE_W +: LANE_W] = a[i*LANE_W +: LANE_W] + b[i*LANE_W +: LANE_W];
		end
		return r;
	endfunction

	function automatic logic [SUM_W-1:0] spread_pixel(input logic [PIX_W-1:0] p);
		logic [SUM_W-1:0] r;
		for (int i = 0; i < NUM_CH; i++) begin
			r[i*LANE_W +: LANE_W] = LANE_W'(p[i*CH_W +: CH_W]);
		end
		return r;
	endfunction

	function automatic logic [PIX_W-1:0] pack_average(input logic [SUM_W-1:0] sum,
		input logic [SHIFT_W-1:0] s);
		logic [PIX_W-1:0]   r;
		logic [LANE_W-1:0]  lane;
		logic [SHIFT_W:0]   sh;
		sh = {s, 1'b0};
		for (int i = 0; i < NUM_CH; i++) begin
			lane = sum[i*LANE_W +: LANE_W] >> sh;
			r[i*CH_W +: CH_W] = lane[CH_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/bfd_ifs.sv
`default_nettype none

interface bfd_src_if import bfd_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] source_pixel;
	logic             frame_start;

	modport source(output valid, source_pixel, frame_start, input ready);
	modport sink(input valid, source_pixel, frame_start, output ready);
endinterface

interface bfd_disp_if import bfd_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] display_pixel;
	logic [POS_W-1:0] out_x;
	logic [POS_W-1:0] out_y;

	modport source(output valid, display_pixel, out_x, out_y, input ready);
	modport sink(input valid, display_pixel, out_x, out_y, output ready);
endinterface

`default_nettype wire

FILE: rtl/box_filter_downscaler.sv
`default_nettype none

// Power-of-two box-filter downscaler: render pixels stream in raster order, one transfer per
// clock while ready, and each display pixel is the per-channel truncated average of its
// square block of 2^scale_shift by 2^scale_shift source pixels. The front end takes one
// pixel every cycle while ready, sums it into the running block-row segment and, at the last
// pixel of a segment, queues one column update; the back end applies one update per cycle to
// the column store (a single read and a single write port, MAX_WIDTH entries capped at 1024)
// unless the output stalls, so the sustained rate is one pixel per cycle. A display pixel
// passes the command queue, stage-1 register and output register after the transfer of the
// bottom-right pixel of its block, and the input keeps flowing while it waits to be taken
// unless the four-entry command queue fills. The column store is not cleared after reset; its
// first row of each block band overwrites it. Configuration changes belong between frames.
module box_filter_downscaler import bfd_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SHIFT = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bfd_src_if.sink               render,
	bfd_disp_if.source            display
);

	logic     push;
	bfd_cmd_t push_cmd;
	logic     queue_full;
	logic     pop;
	bfd_cmd_t pop_cmd;
	logic     queue_nonempty;

	bfd_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_SHIFT(MAX_SHIFT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.render(render),
		.queue_full(queue_full),
		.push(push),
		.push_cmd(push_cmd)
	);

	bfd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(queue_full),
		.pop(pop),
		.pop_cmd(pop_cmd),
		.nonempty(queue_nonempty)
	);

	bfd_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_nonempty(queue_nonempty),
		.q_cmd(pop_cmd),
		.pop(pop),
		.display(display)
	);

endmodule

`default_nettype wire

FILE: rtl/bfd_queue.sv
`default_nettype none

module bfd_queue import bfd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  bfd_cmd_t push_cmd,
	output logic     full,
	input  logic     pop,
	output bfd_cmd_t pop_cmd,
	output logic     nonempty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	bfd_cmd_t         entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_cmd = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bfd_front.sv
`default_nettype none

module bfd_front import bfd_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SHIFT = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bfd_src_if.sink               render,
	input  logic                  queue_full,
	output logic                  push,
	output bfd_cmd_t              push_cmd
);

	localparam int WW = ($clog2(MAX_WIDTH + 1) > DWIDTH_W) ? $clog2(MAX_WIDTH + 1) : DWIDTH_W;

	logic [SHIFT_W-1:0]  scale_shift_q;
	logic [DWIDTH_W-1:0] display_width_q;
	logic [SUM_W-1:0]    run_q;
	logic [SUB_W-1:0]    sub_col_q;
	logic [SUB_W-1:0]    sub_row_q;
	logic [POS_W-1:0]    blk_col_q;
	logic [POS_W-1:0]    blk_row_q;

	logic                accept;
	logic [SHIFT_W-1:0]  s_eff;
	logic [SUB_W-1:0]    last_sub;
	logic [WW-1:0]       dw_ext;
	logic [WW-1:0]       width_eff;
	logic [SUM_W-1:0]    cur_run;
	logic [SUB_W-1:0]    cur_sub_col;
	logic [SUB_W-1:0]    cur_sub_row;
	logic [POS_W-1:0]    cur_blk_col;
	logic [POS_W-1:0]    cur_blk_row;
	logic [SUM_W-1:0]    new_run;
	logic                close;
	logic                row_end;
	logic                emit;

	assign render.ready = !queue_full;
	assign accept = render.valid && render.ready;

	always_comb begin
		if (int'(scale_shift_q) > MAX_SHIFT) begin
			s_eff = SHIFT_W'(MAX_SHIFT);
		end else begin
			s_eff = scale_shift_q;
		end
		last_sub = SUB_W'((4'd1 << s_eff) - 4'd1);

		dw_ext = WW'(display_width_q);
		if (dw_ext == '0) begin
			width_eff = WW'(1);
		end else if (dw_ext > WW'(MAX_WIDTH)) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = dw_ext;
		end

		cur_run = render.frame_start ? '0 : run_q;
		cur_sub_col = render.frame_start ? '0 : sub_col_q;
		cur_sub_row = render.frame_start ? '0 : sub_row_q;
		cur_blk_col = render.frame_start ? '0 : blk_col_q;
		cur_blk_row = render.frame_start ? '0 : blk_row_q;

		new_run = lane_add(cur_run, spread_pixel(render.source_pixel));
		close = (cur_sub_col >= last_sub);
		emit = (cur_sub_row >= last_sub);
		row_end = ((WW'(cur_blk_col) + WW'(1)) >= width_eff);

		push = accept && close;
		push_cmd.seg = new_run;
		push_cmd.x = cur_blk_col;
		push_cmd.y = cur_blk_row;
		push_cmd.first_row = (cur_sub_row == '0);
		push_cmd.emit = emit;
		push_cmd.shift = s_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_shift_q <= '0;
			display_width_q <= DWIDTH_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SCALE_SHIFT: begin
					scale_shift_q <= cfg_data[SHIFT_W-1:0];
				end
				REG_DISPLAY_WIDTH: begin
					display_width_q <= cfg_data[DWIDTH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			sub_col_q <= '0;
			sub_row_q <= '0;
			blk_col_q <= '0;
			blk_row_q <= '0;
		end else if (accept) begin
			sub_row_q <= cur_sub_row;
			blk_col_q <= cur_blk_col;
			blk_row_q <= cur_blk_row;
			if (close) begin
				run_q <= '0;
				sub_col_q <= '0;
				if (row_end) begin
					blk_col_q <= '0;
					if (emit) begin
						sub_row_q <= '0;
						blk_row_q <= cur_blk_row + 1'b1;
					end else begin
						sub_row_q <= cur_sub_row + 1'b1;
					end
				end else begin
					blk_col_q <= cur_blk_col + 1'b1;
				end
			end else begin
				run_q <= new_run;
				sub_col_q <= cur_sub_col + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bfd_back.sv
`default_nettype none

module bfd_back import bfd_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_nonempty,
	input  bfd_cmd_t q_cmd,
	output logic     pop,
	bfd_disp_if.source display
);

	localparam int DEPTH = (MAX_WIDTH < (1 << POS_W)) ? MAX_WIDTH : (1 << POS_W);
	localparam int IDX_W = $clog2(DEPTH);

	logic [SUM_W-1:0] col_mem [DEPTH];

	logic             vld_s1;
	bfd_cmd_t         cmd_s1;
	logic [SUM_W-1:0] rd_data_s1;
	logic             byp_s1;
	logic [SUM_W-1:0] byp_data_s1;

	logic             out_vld_q;
	logic [PIX_W-1:0] out_pixel_q;
	logic [POS_W-1:0] out_x_q;
	logic [POS_W-1:0] out_y_q;

	logic [IDX_W-1:0] idx_pop;
	logic [IDX_W-1:0] idx_s1;
	logic [SUM_W-1:0] base;
	logic [SUM_W-1:0] total;
	logic             done;
	logic             advance;

	always_comb begin
		idx_pop = q_cmd.x[IDX_W-1:0];
		idx_s1 = cmd_s1.x[IDX_W-1:0];
		base = byp_s1 ? byp_data_s1 : rd_data_s1;
		total = cmd_s1.first_row ? cmd_s1.seg : lane_add(base, cmd_s1.seg);
		done = !cmd_s1.emit || !out_vld_q || display.ready;
		advance = vld_s1 && done;
		pop = q_nonempty && (!vld_s1 || done);
	end

	// The read of the next command sees the old entry when the current one writes
	// the same column in the same cycle, so the fresh sum is carried alongside.
	always_ff @(posedge clk) begin
		if (advance) begin
			col_mem[idx_s1] <= total;
		end
		if (pop) begin
			rd_data_s1 <= col_mem[idx_pop];
			cmd_s1 <= q_cmd;
			byp_s1 <= advance && (idx_s1 == idx_pop);
			byp_data_s1 <= total;
		end
		if (advance && cmd_s1.emit) begin
			out_pixel_q <= pack_average(total, cmd_s1.shift);
			out_x_q <= cmd_s1.x;
			out_y_q <= cmd_s1.y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance && cmd_s1.emit) begin
				out_vld_q <= 1'b1;
			end else if (display.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign display.valid = out_vld_q;
	assign display.display_pixel = out_pixel_q;
	assign display.out_x = out_x_q;
	assign display.out_y = out_y_q;

endmodule

`default_nettype wire

FILE: rtl/bfd_checker.sv
`default_nettype none

`include "box_filter_downscaler_defines.svh"

module bfd_checker import bfd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             render_valid,
	input logic             render_ready,
	input logic             display_valid,
	input logic             display_ready,
	input logic [PIX_W-1:0] display_pixel,
	input logic [POS_W-1:0] out_x,
	input logic [POS_W-1:0] out_y
);

	`BFD_ASSERT_ALWAYS(a_reset_no_output, clk, (arst_n || !display_valid), "Output valid during reset.")
	`BFD_ASSERT_NEXT(a_valid_holds, clk, arst_n, (display_valid && !display_ready), display_valid, "Output valid dropped before its transfer.")
	`BFD_ASSERT_NEXT(a_payload_holds, clk, arst_n, (display_valid && !display_ready), ($stable(display_pixel) && $stable(out_x) && $stable(out_y)), "Stalled output payload changed.")
	`BFD_ASSERT_IMPL(a_input_drains, clk, arst_n, $past(display_ready), render_ready, "Input stalled although the output side was ready.")

endmodule

bind box_filter_downscaler bfd_checker u_bfd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.render_valid(render.valid),
	.render_ready(render.ready),
	.display_valid(display.valid),
	.display_ready(display.ready),
	.display_pixel(display.display_pixel),
	.out_x(display.out_x),
	.out_y(display.out_y)
);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import bfd_pkg::*;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
	} display_item_t;

	localparam int STORE_DEPTH = 1024;
	localparam int SETTLE_CYCLES = 16;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bfd_src_if render_if();
	bfd_disp_if display_if();

	box_filter_downscaler dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.render(render_if),
		.display(display_if)
	);

	logic [SHIFT_W-1:0] shift_reg;
	logic [DWIDTH_W-1:0] width_reg;
	logic [SUM_W-1:0] column_acc [STORE_DEPTH];
	logic [SUM_W-1:0] segment_sum;
	int unsigned sub_x;
	int unsigned sub_y;
	int unsigned blk_x;
	int unsigned blk_y;

	display_item_t pending_pixels[$];
	int mismatches;
	bit src_idle_en;
	bit sink_stall_en;

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic void predict_downscale(input logic [PIX_W-1:0] pix, input logic fs);
		int unsigned s;
		int unsigned w;
		int unsigned last;
		logic [SUM_W-1:0] total;
		logic [LANE_W-1:0] lane_r;
		logic [LANE_W-1:0] lane_g;
		logic [LANE_W-1:0] lane_b;
		display_item_t item;
		s = shift_reg;
		w = width_reg;
		if (w == 0) begin
			w = 1;
		end
		if (w > STORE_DEPTH) begin
			w = STORE_DEPTH;
		end
		last = (1 << s) - 1;
		if (fs) begin
			sub_x = 0;
			sub_y = 0;
			blk_x = 0;
			blk_y = 0;
			segment_sum = '0;
		end
		segment_sum = segment_sum + {6'd0, pix[23:16], 6'd0, pix[15:8], 6'd0, pix[7:0]};
		if (sub_x >= last) begin
			total = (sub_y == 0) ? segment_sum : column_acc[blk_x] + segment_sum;
			column_acc[blk_x] = total;
			segment_sum = '0;
			if (sub_y >= last) begin
				lane_r = total[41:28] >> (2 * s);
				lane_g = total[27:14] >> (2 * s);
				lane_b = total[13:0] >> (2 * s);
				item.pixel = {lane_r[7:0], lane_g[7:0], lane_b[7:0]};
				item.x = POS_W'(blk_x);
				item.y = POS_W'(blk_y);
				pending_pixels.push_back(item);
			end
			sub_x = 0;
			if (blk_x + 1 >= w) begin
				blk_x = 0;
				if (sub_y >= last) begin
					sub_y = 0;
					blk_y = (blk_y + 1) % STORE_DEPTH;
				end else begin
					sub_y = sub_y + 1;
				end
			end else begin
				blk_x = blk_x + 1;
			end
		end else begin
			sub_x = sub_x + 1;
		end
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
		while (src_idle_en && $urandom_range(0, 99) < 20) begin
			render_if.valid <= 1'b0;
			@(posedge clk);
		end
		render_if.valid <= 1'b1;
		render_if.source_pixel <= pix;
		render_if.frame_start <= fs;
		do @(posedge clk); while (!render_if.ready);
		predict_downscale(pix, fs);
	endtask

	task automatic hold_until_drained();
		render_if.valid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
	endtask

	task automatic wait_idle();
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_scale(input logic [SHIFT_W-1:0] shift, input logic [DWIDTH_W-1:0] width);
		cfg_we <= 1'b1;
		cfg_index <= REG_SCALE_SHIFT;
		cfg_data <= CFG_DATA_W'(shift);
		@(posedge clk);
		shift_reg = shift;
		cfg_index <= REG_DISPLAY_WIDTH;
		cfg_data <= CFG_DATA_W'(width);
		@(posedge clk);
		width_reg = width;
		cfg_we <= 1'b0;
	endtask

	function automatic logic [PIX_W-1:0] random_pixel();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
		end
		return PIX_W'($urandom);
	endfunction

	task automatic test_reset_passthrough();
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'hFFFFFF, 1'b0);
		send_pixel(24'hA5C35A, 1'b0);
		send_pixel(24'h5A3CA5, 1'b1);
		wait_idle();
	endtask

	task automatic test_zero_width();
		set_scale(2'd0, 11'd0);
		send_pixel(24'h123456, 1'b1);
		send_pixel(24'h800001, 1'b0);
		send_pixel(24'h7FFFFE, 1'b0);
		wait_idle();
	endtask

	task automatic test_block_average();
		set_scale(2'd1, 11'd1);
		send_pixel(24'hFFFFFF, 1'b1);
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'h010101, 1'b0);
		send_pixel(24'hFEFEFE, 1'b0);
		wait_idle();
	endtask

	task automatic test_width_change_midrow();
		set_scale(2'd0, 11'd8);
		send_pixel(random_pixel(), 1'b1);
		repeat (4) send_pixel(random_pixel(), 1'b0);
		wait_idle();
		set_scale(2'd0, 11'd3);
		send_pixel(random_pixel(), 1'b0);
		send_pixel(random_pixel(), 1'b0);
		wait_idle();
	endtask

	task automatic test_shift_change_midblock();
		set_scale(2'd2, 11'd2);
		send_pixel(random_pixel(), 1'b1);
		repeat (2) send_pixel(random_pixel(), 1'b0);
		wait_idle();
		set_scale(2'd1, 11'd2);
		repeat (7) send_pixel(random_pixel(), 1'b0);
		wait_idle();
	endtask

	task automatic test_width_saturation();
		src_idle_en = 1'b0;
		sink_stall_en = 1'b0;
		set_scale(2'd0, 11'd2047);
		for (int i = 0; i < 1030; i++) begin
			send_pixel(random_pixel(), i == 0);
		end
		wait_idle();
		src_idle_en = 1'b1;
		sink_stall_en = 1'b1;
	endtask

	task automatic test_random_frames();
		int unsigned done_items;
		int unsigned s;
		int unsigned w;
		int unsigned cap;
		int unsigned band;
		int unsigned total;
		logic fs;
		done_items = 0;
		while (done_items < 300) begin
			s = $urandom_range(0, 3);
			cap = 256 >> (2 * s);
			if ($urandom_range(0, 9) == 0) begin
				w = $urandom_range(0, 1) ? 1 : cap;
			end else begin
				w = $urandom_range(1, (cap < 12) ? cap : 12);
			end
			band = w << (2 * s);
			total = ((band <= 64) ? $urandom_range(1, 3) : 1) * band + $urandom_range(0, band / 2);
			src_idle_en = $urandom_range(0, 3) != 0;
			sink_stall_en = $urandom_range(0, 3) != 0;
			set_scale(SHIFT_W'(s), DWIDTH_W'(w));
			for (int i = 0; i < total; i++) begin
				fs = (i == 0) || ($urandom_range(0, 99) == 0);
				if ($urandom_range(0, 299) == 0) begin
					hold_until_drained();
				end
				send_pixel(random_pixel(), fs);
			end
			done_items += total;
			wait_idle();
		end
		src_idle_en = 1'b1;
		sink_stall_en = 1'b1;
	endtask

	always @(posedge clk) begin
		display_if.ready <= !sink_stall_en || ($urandom_range(0, 99) >= 20);
	end

	always @(posedge clk) begin : check_display
		display_item_t want;
		if (arst_n && display_if.valid && display_if.ready) begin
			if (pending_pixels.size() == 0) begin
				if (mismatches < 10) begin
					$display("unexpected display transfer: pixel %h x %0d y %0d",
						display_if.display_pixel, display_if.out_x, display_if.out_y);
				end
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				if (display_if.display_pixel !== want.pixel || display_if.out_x !== want.x ||
					display_if.out_y !== want.y) begin
					if (mismatches < 10) begin
						$display("display mismatch: expected pixel %h x %0d y %0d, got pixel %h x %0d y %0d",
							want.pixel, want.x, want.y,
							display_if.display_pixel, display_if.out_x, display_if.out_y);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SCALE_SHIFT;
		cfg_data = '0;
		render_if.valid = 1'b0;
		render_if.source_pixel = '0;
		render_if.frame_start = 1'b0;
		display_if.ready = 1'b0;
		shift_reg = '0;
		width_reg = DWIDTH_RESET;
		segment_sum = '0;
		sub_x = 0;
		sub_y = 0;
		blk_x = 0;
		blk_y = 0;
		mismatches = 0;
		src_idle_en = 1'b1;
		sink_stall_en = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_passthrough();
		test_zero_width();
		test_block_average();
		test_width_change_midrow();
		test_shift_change_midblock();
		test_width_saturation();
		test_random_frames();

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_pixels.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
